[rtl/pida_pkg.sv]
`timescale 1ns / 1ps

package pida_pkg;

   localparam int KIND_W   = 2;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;
   localparam int CAP_W    = 5;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD    = 2'd0,
      KIND_INSERT  = 2'd1,
      KIND_DELETE  = 2'd2,
      KIND_DISPLAY = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 3'd0,
      STATUS_NOT_CREATED  = 3'd1,
      STATUS_FULL         = 3'd2,
      STATUS_BAD_POSITION = 3'd3,
      STATUS_EMPTY        = 3'd4
   } status_type;

   // what every cell of the chain does at each clock edge
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_ROTATE = 2'd3
   } cell_op_type;

endpackage

[rtl/pida_req_if.sv]
`timescale 1ns / 1ps

interface pida_req_if;
   import pida_pkg::*;

   logic                       valid;
   logic                       ready;
   logic        [KIND_W-1:0]   kind;
   logic        [POS_W-1:0]    position;
   logic signed [VALUE_W-1:0]  item_value;

   modport source (output valid, kind, position, item_value, input ready);
   modport sink   (input valid, kind, position, item_value, output ready);
endinterface

[rtl/pida_rsp_if.sv]
`timescale 1ns / 1ps

interface pida_rsp_if;
   import pida_pkg::*;

   logic                       valid;
   logic                       ready;
   logic        [STATUS_W-1:0] status;
   logic signed [VALUE_W-1:0]  read_value;
   logic        [COUNT_W-1:0]  element_count;
   logic                       last;

   modport source (output valid, status, read_value, element_count, last, input ready);
   modport sink   (input valid, status, read_value, element_count, last, output ready);
endinterface

[rtl/pida_cell.sv]
`timescale 1ns / 1ps

module pida_cell #(
   parameter int DEPTH = 16,
   parameter int INDEX = 0
) (
   input  logic                                 clock,
   input  pida_pkg::cell_op_type                cmd_op,
   input  logic [$clog2(DEPTH+1)-1:0]           cmd_at,
   input  logic [$clog2(DEPTH+1)-1:0]           cmd_cnt,
   input  logic signed [pida_pkg::VALUE_W-1:0]  bcast_value,
   input  logic signed [pida_pkg::VALUE_W-1:0]  left_value,
   input  logic signed [pida_pkg::VALUE_W-1:0]  right_value,
   output logic signed [pida_pkg::VALUE_W-1:0]  value_ff
);
   import pida_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] IDX      = CW'(INDEX);
   localparam logic [CW-1:0] IDX_NEXT = CW'(INDEX + 1);

   logic signed [VALUE_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      unique case (cmd_op)
         OP_HOLD: begin
         end
         OP_INSERT: begin
            // cells from the slot up to the old end move up by one
            if (IDX == cmd_at) begin
               value_in = bcast_value;
            end else if (IDX > cmd_at && IDX <= cmd_cnt) begin
               value_in = left_value;
            end
         end
         OP_DELETE: begin
            if (IDX >= cmd_at && IDX_NEXT < cmd_cnt) begin
               value_in = right_value;
            end
         end
         OP_ROTATE: begin
            // head wraps to the tail of the occupied part
            if (IDX_NEXT < cmd_cnt) begin
               value_in = right_value;
            end else if (IDX_NEXT == cmd_cnt) begin
               value_in = bcast_value;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

[rtl/positional_insert_delete_array.sv]
`timescale 1ns / 1ps
// channel  direction  payload
// req_if   in         kind, position, item_value
// rsp_if   out        status, read_value, element_count, last
// csr      in         csr_write_data = array_capacity
//
// Load, insert, delete and errors: one request per cycle while results are taken, result registered in the cycle after.
// Display: the request cycle loads no result, then one result per cycle while results are taken,
// one for each stored element; the elements leave through cell 0 while the cell chain rotates
// by one with each result.
// Reset (synchronous) empties the array, clears the created flag, capacity returns to 16.
// A stalled result holds the output register and blocks new requests and the rotation.

module positional_insert_delete_array #(
   parameter int DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   pida_req_if.sink                        req_if,
   pida_rsp_if.source                      rsp_if,
   input  logic                            csr_write_enable,
   input  logic [pida_pkg::CAP_W-1:0]      csr_write_data
);
   import pida_pkg::*;

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   typedef enum logic {ST_IDLE, ST_EMIT} state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic                      created_ff, created_in;
   logic [CAP_W-1:0]          capacity_ff;
   logic [CW-1:0]             emit_idx_ff, emit_idx_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                      rsp_last_ff, rsp_last_in;

   cell_op_type               cmd_op;
   logic [CW-1:0]             cmd_at;
   logic signed [VALUE_W-1:0] bcast_value;
   logic signed [VALUE_W-1:0] cell_value [DEPTH];

   logic                      slot_free;
   logic                      accept;
   logic                      full;
   logic                      pos_bad;
   logic [CMPW-1:0]           pos_ext;
   logic [CMPW-1:0]           cnt_ext;
   logic [CW-1:0]             at_pos;
   logic                      emit_last;

   assign slot_free    = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE) && slot_free;
   assign accept       = req_if.valid && req_if.ready;

   assign pos_ext = CMPW'(req_if.position);
   assign cnt_ext = CMPW'(count_ff);
   assign full    = (cnt_ext >= CMPW'(capacity_ff)) || (count_ff >= DEPTH_CNT);
   assign pos_bad = (req_if.position == '0) || (pos_ext > cnt_ext);
   assign at_pos  = CW'(pos_ext - CMPW'(1));
   assign emit_last = (emit_idx_ff + CW'(1)) == count_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      created_in    = created_ff;
      emit_idx_in   = emit_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      cmd_op        = OP_HOLD;
      cmd_at        = count_ff;
      bcast_value   = req_if.item_value;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
               unique case (kind_type'(req_if.kind))
                  KIND_LOAD: begin
                     created_in = 1'b1;
                     if (full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        cmd_op   = OP_INSERT;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  KIND_INSERT: begin
                     priority if (!created_ff) begin
                        rsp_status_in = STATUS_NOT_CREATED;
                     end else if (full) begin
                        rsp_status_in = STATUS_FULL;
                     end else if (pos_bad) begin
                        rsp_status_in = STATUS_BAD_POSITION;
                     end else begin
                        cmd_op   = OP_INSERT;
                        cmd_at   = at_pos;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  KIND_DELETE: begin
                     priority if (!created_ff) begin
                        rsp_status_in = STATUS_NOT_CREATED;
                     end else if (count_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else if (pos_bad) begin
                        rsp_status_in = STATUS_BAD_POSITION;
                     end else begin
                        cmd_op   = OP_DELETE;
                        cmd_at   = at_pos;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  KIND_DISPLAY: begin
                     priority if (!created_ff) begin
                        rsp_status_in = STATUS_NOT_CREATED;
                     end else if (count_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_EMIT;
                        emit_idx_in  = '0;
                     end
                  end
               endcase
               rsp_count_in = COUNT_W'(count_in);
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               cmd_op        = OP_ROTATE;
               cmd_at        = '0;
               bcast_value   = cell_value[0];
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_value_in  = cell_value[0];
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_last_in   = emit_last;
               emit_idx_in   = emit_idx_ff + CW'(1);
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         created_ff   <= 1'b0;
         capacity_ff  <= CAPACITY_RESET;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         created_ff    <= created_in;
         emit_idx_ff   <= emit_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_last_ff   <= rsp_last_in;
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
      end
   end

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic signed [VALUE_W-1:0] left_value;
         logic signed [VALUE_W-1:0] right_value;

         if (g == 0) begin : g_head
            assign left_value = '0;
         end else begin : g_body
            assign left_value = cell_value[g-1];
         end

         if (g == DEPTH - 1) begin : g_tail
            assign right_value = '0;
         end else begin : g_inner
            assign right_value = cell_value[g+1];
         end

         pida_cell #(
            .DEPTH (DEPTH),
            .INDEX (g)
         ) u_cell (
            .clock       (clock),
            .cmd_op      (cmd_op),
            .cmd_at      (cmd_at),
            .cmd_cnt     (count_ff),
            .bcast_value (bcast_value),
            .left_value  (left_value),
            .right_value (right_value),
            .value_ff    (cell_value[g])
         );
      end
   endgenerate

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.read_value    = rsp_value_ff;
   assign rsp_if.element_count = rsp_count_ff;
   assign rsp_if.last          = rsp_last_ff;

endmodule

[rtl/pida_checker.sv]
`timescale 1ns / 1ps

module pida_checker #(
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [pida_pkg::STATUS_W-1:0]        rsp_status,
   input  logic signed [pida_pkg::VALUE_W-1:0]  rsp_read_value,
   input  logic [pida_pkg::COUNT_W-1:0]         rsp_element_count,
   input  logic                                 rsp_last
);
   import pida_pkg::*;

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_read_value) && $stable(rsp_element_count) && $stable(rsp_last))
      else $error("result changed while stalled");

   // no new request while the output register is blocked
   a_no_take_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !(req_valid && req_ready))
      else $error("request taken while result stalled");

   // errors are single results
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_last)
      else $error("error result not marked last");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_read_value == '0)
      else $error("error result carries a value");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_element_count) <= DEPTH)
      else $error("element count beyond depth");

endmodule

bind positional_insert_delete_array pida_checker #(
   .DEPTH (DEPTH)
) u_pida_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_status        (rsp_if.status),
   .rsp_read_value    (rsp_if.read_value),
   .rsp_element_count (rsp_if.element_count),
   .rsp_last          (rsp_if.last)
);
